/* rtl/keypad_code_lock_fsm_core_macros.svh */
// Assertion macros shared by the code lock checker.
`ifndef KEYPAD_CODE_LOCK_FSM_CORE_MACROS_SVH
`define KEYPAD_CODE_LOCK_FSM_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KCLF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("code lock check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define KCLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("code lock check failed in the following cycle");

`endif

/* rtl/kclf_pkg.sv */
// Shared types and constants of the keypad code lock.
package kclf_pkg;

  // Field widths of the event and result channels.
  localparam int unsigned KEY_W    = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned COUNT_W  = 4;

  // Default number of digits in a code.
  localparam int unsigned CODE_LENGTH_DEF = 4;

  // Event kinds on the input channel.
  localparam logic REQ_KEY    = 1'b0;
  localparam logic REQ_BUTTON = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_NONE        = 3'd0,
    ST_UNLOCK      = 3'd1,
    ST_WRONG       = 3'd2,
    ST_ASK_NEW     = 3'd3,
    ST_ASK_CONFIRM = 3'd4,
    ST_SAVED       = 3'd5,
    ST_ASK_OLD     = 3'd6,
    ST_CANCELLED   = 3'd7
  } status_t;

  // Lock modes as seen on the result channel.
  localparam logic [MODE_W-1:0] MODE_CODE_NORMAL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_VERIFY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_NEW     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_CONFIRM = 2'd3;

endpackage

/* rtl/kclf_if.sv */
// Valid/ready channel interfaces for events and results of the code lock.
interface kclf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [kclf_pkg::KEY_W-1:0]  key_value;

  modport source (output valid, output req_type, output key_value, input ready);
  modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface kclf_out_if;
  logic                           valid;
  logic                           ready;
  logic [kclf_pkg::STATUS_W-1:0]  status;
  logic                           door_open;
  logic                           key_accepted;
  logic [kclf_pkg::MODE_W-1:0]    mode_now;
  logic [kclf_pkg::COUNT_W-1:0]   digits_held;

  modport source (output valid, output status, output door_open, output key_accepted,
                  output mode_now, output digits_held, input ready);
  modport sink   (input valid, input status, input door_open, input key_accepted,
                  input mode_now, input digits_held, output ready);
endinterface

/* rtl/keypad_code_lock_fsm_core.sv */
// Keypad code lock: collects key digits, checks and changes the code.
// An event passes the input register, then the result register; a stalled result
// register holds stage 1 back. Throughput: one event per cycle while the result channel
// does not stall; the single-pass judge logic sets that figure.
// Reset (rst_n low, synchronous) empties both registers, returns the lock to normal
// mode with no digits held, and clears entry, working and saved codes to zero.
module keypad_code_lock_fsm_core #(
  parameter int unsigned CODE_LENGTH = kclf_pkg::CODE_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  kclf_in_if.sink     in_if,
  kclf_out_if.source  out_if
);

  // One-hot lock mode.
  typedef enum logic [3:0] {
    MODE_NORMAL  = 4'b0001,
    MODE_VERIFY  = 4'b0010,
    MODE_NEW     = 4'b0100,
    MODE_CONFIRM = 4'b1000
  } mode_t;

  typedef logic [kclf_pkg::KEY_W-1:0] digit_t;

  // Input register.
  logic                       s1_valid_r;
  logic                       s1_req_r;
  digit_t                     s1_key_r;

  // Lock state.
  mode_t                         mode_r, mode_nxt;
  logic [kclf_pkg::COUNT_W-1:0]  count_r, count_nxt;
  digit_t                        entry_r [CODE_LENGTH];
  digit_t                        entry_nxt [CODE_LENGTH];
  digit_t                        work_r [CODE_LENGTH];
  digit_t                        work_nxt [CODE_LENGTH];
  digit_t                        saved_r [CODE_LENGTH];
  digit_t                        saved_nxt [CODE_LENGTH];

  // Result register.
  logic                          out_valid_r;
  kclf_pkg::status_t             out_status_r, status_nxt;
  logic                          out_door_r, door_nxt;
  logic                          out_acc_r, acc_nxt;
  logic [kclf_pkg::MODE_W-1:0]   out_mode_r, mode_code_nxt;
  logic [kclf_pkg::COUNT_W-1:0]  out_count_r;

  logic                          s1_adv;
  logic                          key_take;
  logic [kclf_pkg::COUNT_W-1:0]  count_inc;
  logic                          entry_full;
  logic                          code_match;
  digit_t                        entry_upd [CODE_LENGTH];

  // Stage 1 moves on when the result register is free or being drained.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;

  // Input register: capture each event transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
    if (in_if.valid && in_if.ready) begin
      s1_req_r <= in_if.req_type;
      s1_key_r <= in_if.key_value;
    end
  end

  // A nonzero key is stored while the buffer has room.
  assign key_take  = (s1_req_r == kclf_pkg::REQ_KEY) && (s1_key_r != '0) &&
                     (count_r < kclf_pkg::COUNT_W'(CODE_LENGTH));
  assign count_inc = count_r + kclf_pkg::COUNT_W'(key_take);
  assign entry_full = (count_inc >= kclf_pkg::COUNT_W'(CODE_LENGTH));

  // Entry buffer with the new digit in place, and its compare to the working code.
  always_comb begin
    code_match = 1'b1;
    for (int i = 0; i < int'(CODE_LENGTH); i++) begin
      entry_upd[i] = (key_take && (count_r == kclf_pkg::COUNT_W'(i))) ? s1_key_r : entry_r[i];
      if (entry_upd[i] != work_r[i]) begin
        code_match = 1'b0;
      end
    end
  end

  // Mode and code updates for one event.
  always_comb begin
    mode_nxt   = mode_r;
    count_nxt  = count_r;
    status_nxt = kclf_pkg::ST_NONE;
    door_nxt   = 1'b0;
    acc_nxt    = 1'b0;
    for (int i = 0; i < int'(CODE_LENGTH); i++) begin
      entry_nxt[i] = entry_r[i];
      work_nxt[i]  = work_r[i];
      saved_nxt[i] = saved_r[i];
    end
    if (s1_req_r == kclf_pkg::REQ_KEY) begin
      acc_nxt   = key_take;
      count_nxt = count_inc;
      for (int i = 0; i < int'(CODE_LENGTH); i++) begin
        entry_nxt[i] = entry_upd[i];
      end
      if (entry_full) begin
        count_nxt = '0;
        if (mode_r == MODE_NEW) begin
          // A new code is taken without any compare.
          for (int i = 0; i < int'(CODE_LENGTH); i++) begin
            work_nxt[i] = entry_upd[i];
          end
          mode_nxt   = MODE_CONFIRM;
          status_nxt = kclf_pkg::ST_ASK_CONFIRM;
        end else if (!code_match) begin
          status_nxt = kclf_pkg::ST_WRONG;
        end else begin
          case (mode_r)
            MODE_NORMAL: begin
              door_nxt   = 1'b1;
              status_nxt = kclf_pkg::ST_UNLOCK;
            end
            MODE_VERIFY: begin
              mode_nxt   = MODE_NEW;
              status_nxt = kclf_pkg::ST_ASK_NEW;
            end
            default: begin
              // Confirmed: commit the working code to the saved copy.
              for (int i = 0; i < int'(CODE_LENGTH); i++) begin
                saved_nxt[i] = work_r[i];
              end
              mode_nxt   = MODE_NORMAL;
              status_nxt = kclf_pkg::ST_SAVED;
            end
          endcase
        end
      end
    end else begin
      count_nxt = '0;
      if (mode_r == MODE_NORMAL) begin
        mode_nxt   = MODE_VERIFY;
        status_nxt = kclf_pkg::ST_ASK_OLD;
      end else begin
        // Cancel: restore the working code from the saved copy.
        for (int i = 0; i < int'(CODE_LENGTH); i++) begin
          work_nxt[i] = saved_r[i];
        end
        mode_nxt   = MODE_NORMAL;
        status_nxt = kclf_pkg::ST_CANCELLED;
      end
    end
  end

  // Encode the mode after the step for the result channel.
  always_comb begin
    case (mode_nxt)
      MODE_NORMAL:  mode_code_nxt = kclf_pkg::MODE_CODE_NORMAL;
      MODE_VERIFY:  mode_code_nxt = kclf_pkg::MODE_CODE_VERIFY;
      MODE_NEW:     mode_code_nxt = kclf_pkg::MODE_CODE_NEW;
      MODE_CONFIRM: mode_code_nxt = kclf_pkg::MODE_CODE_CONFIRM;
      default:      mode_code_nxt = kclf_pkg::MODE_CODE_NORMAL;
    endcase
  end

  // Lock state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      count_r <= '0;
      for (int i = 0; i < int'(CODE_LENGTH); i++) begin
        entry_r[i] <= '0;
        work_r[i]  <= '0;
        saved_r[i] <= '0;
      end
    end else if (s1_adv) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < int'(CODE_LENGTH); i++) begin
        entry_r[i] <= entry_nxt[i];
        work_r[i]  <= work_nxt[i];
        saved_r[i] <= saved_nxt[i];
      end
    end
  end

  // Result register: loaded as stage 1 moves on, drained by a result transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv) begin
      out_status_r <= status_nxt;
      out_door_r   <= door_nxt;
      out_acc_r    <= acc_nxt;
      out_mode_r   <= mode_code_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.door_open    = out_door_r;
  assign out_if.key_accepted = out_acc_r;
  assign out_if.mode_now     = out_mode_r;
  assign out_if.digits_held  = out_count_r;

endmodule

/* rtl/kclf_checker.sv */
// Port-level checks of the code lock, bound to its top level.
`include "keypad_code_lock_fsm_core_macros.svh"

module kclf_checker #(
  parameter int unsigned CODE_LENGTH = kclf_pkg::CODE_LENGTH_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [kclf_pkg::STATUS_W-1:0]  status,
  input logic                           door_open,
  input logic [kclf_pkg::MODE_W-1:0]    mode_now,
  input logic [kclf_pkg::COUNT_W-1:0]   digits_held
);

  // A stalled result keeps its payload until the transfer.
  `KCLF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(door_open) && $stable(mode_now) && $stable(digits_held))

  // The door opens only on an unlock in normal mode.
  `KCLF_ASSERT_SAME(a_door_unlock, clk, rst_n, out_valid && door_open, status == kclf_pkg::ST_UNLOCK && mode_now == kclf_pkg::MODE_CODE_NORMAL)

  // A cancel returns to normal mode with an empty buffer.
  `KCLF_ASSERT_SAME(a_cancel_state, clk, rst_n, out_valid && status == kclf_pkg::ST_CANCELLED, mode_now == kclf_pkg::MODE_CODE_NORMAL && digits_held == '0)

  // The buffer never reports a full code; it is judged as it fills.
  `KCLF_ASSERT_SAME(a_count_range, clk, rst_n, out_valid, digits_held < kclf_pkg::COUNT_W'(CODE_LENGTH))

endmodule

bind keypad_code_lock_fsm_core kclf_checker #(
  .CODE_LENGTH(CODE_LENGTH)
) u_kclf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .status      (out_if.status),
  .door_open   (out_if.door_open),
  .mode_now    (out_if.mode_now),
  .digits_held (out_if.digits_held)
);
